FILE: src/circular_list_position_ops_assert.svh
// Assertion macros shared by the list RTL.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef CIRCULAR_LIST_POSITION_OPS_ASSERT_SVH
`define CIRCULAR_LIST_POSITION_OPS_ASSERT_SVH

// Same-cycle implication.
`define CLPO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLPO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/clpo_pkg.sv
// ---------------------------------------------------------------------------
// clpo_pkg
// Types, sizes and codes for the circular list position operations block.
// ---------------------------------------------------------------------------
`default_nettype none

package clpo_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 7;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 7;

    // width for position/count compares, one bit of headroom for count + 1
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } clpo_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [OUT_CNT_W-1:0]    count;
        logic signed [VAL_W-1:0] removed_value;
    } clpo_out_t;

    // access request from the sequencer to the value and link stores
    typedef struct packed {
        logic             link_rd_en;
        logic [IDX_W-1:0] link_rd_addr;
        logic             link_wr_en;
        logic [IDX_W-1:0] link_wr_addr;
        logic [IDX_W-1:0] link_wr_data;
        logic             val_rd_en;
        logic [IDX_W-1:0] val_rd_addr;
        logic             val_wr_en;
        logic [IDX_W-1:0] val_wr_addr;
        logic [VAL_W-1:0] val_wr_data;
    } clpo_store_req_t;

endpackage

`default_nettype wire

FILE: src/clpo_store.sv
// ---------------------------------------------------------------------------
// clpo_store
// Value memory and link memory, one read and one write port each, registered
// read data. Link entries never written read as the next slot, modulo size.
// ---------------------------------------------------------------------------
`default_nettype none

module clpo_store (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire clpo_pkg::clpo_store_req_t req,
    output logic [clpo_pkg::IDX_W-1:0]   link_rdata,
    output logic [clpo_pkg::VAL_W-1:0]   val_rdata
);
    import clpo_pkg::*;

    logic [VAL_W-1:0]    val_mem  [CAPACITY];
    logic [IDX_W-1:0]    link_mem [CAPACITY];
    logic [CAPACITY-1:0] link_vld_reg;
    logic [IDX_W-1:0]    link_rdata_reg;
    logic [VAL_W-1:0]    val_rdata_reg;
    logic [IDX_W-1:0]    succ_addr;

    assign succ_addr = (req.link_rd_addr == IDX_W'(CAPACITY - 1)) ? '0
                                                                   : req.link_rd_addr + 1'b1;

    always_ff @(posedge aclk) begin
        if (req.val_wr_en) begin
            val_mem[req.val_wr_addr] <= req.val_wr_data;
        end
        if (req.val_rd_en) begin
            val_rdata_reg <= val_mem[req.val_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.link_wr_en) begin
            link_mem[req.link_wr_addr] <= req.link_wr_data;
        end
        if (req.link_rd_en) begin
            link_rdata_reg <= link_vld_reg[req.link_rd_addr] ? link_mem[req.link_rd_addr]
                                                             : succ_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (req.link_wr_en) begin
            link_vld_reg[req.link_wr_addr] <= 1'b1;
        end
    end

    assign link_rdata = link_rdata_reg;
    assign val_rdata  = val_rdata_reg;

endmodule

`default_nettype wire

FILE: src/circular_list_position_ops.sv
// ---------------------------------------------------------------------------
// circular_list_position_ops
// Bounded list of signed values kept as a linked chain with a free chain.
// ---------------------------------------------------------------------------
// Input words (s_data: op, value, position) enter on s_valid/s_ready; one
// result word (m_data: status, count, removed_value) leaves on
// m_valid/m_ready for every input word. One request is worked at a time:
// s_ready is high only while the sequencer is idle.
// States from accept to S_EMIT, which loads the output register once it is free:
//   rejected request (full, empty, bad position, unused op): straight to S_EMIT
//   insert front/back, delete front:  S_INS_FRONT, S_INS_BACK or S_DEL_FRONT
//   positional insert:  S_WALK (walk from head, one link read a cycle), S_MI_LINK, S_MI_SPLICE
//   positional delete:  S_WALK, S_MD_UNLINK, S_MD_FREE
//   delete back:        S_WALK up to the entry before the tail
// The walk is bound by the link memory read port, used once per step.
// The result sits in an output register; if the receiver stalls, the
// finished request waits there and the next word is not taken until the
// previous result has moved out of the sequencer.
// Reset empties the list and rebuilds the free chain at once through valid
// bits on the link memory; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "circular_list_position_ops_assert.svh"

module circular_list_position_ops (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire clpo_pkg::clpo_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output clpo_pkg::clpo_out_t     m_data
);
    import clpo_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_FRONT = 4'd1;
    localparam logic [3:0] S_INS_BACK  = 4'd2;
    localparam logic [3:0] S_DEL_FRONT = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_MI_LINK   = 4'd5;
    localparam logic [3:0] S_MI_SPLICE = 4'd6;
    localparam logic [3:0] S_MD_UNLINK = 4'd7;
    localparam logic [3:0] S_MD_FREE   = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    localparam logic [1:0] WK_MID_INS  = 2'd0;
    localparam logic [1:0] WK_MID_DEL  = 2'd1;
    localparam logic [1:0] WK_DEL_BACK = 2'd2;

    logic [3:0]        state_reg,   state_next;
    logic [1:0]        kind_reg,    kind_next;
    logic [IDX_W-1:0]  head_reg,    head_next;
    logic [IDX_W-1:0]  tail_reg,    tail_next;
    logic [IDX_W-1:0]  free_reg,    free_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  steps_reg,   steps_next;
    logic [IDX_W-1:0]  cur_reg,     cur_next;
    logic [IDX_W-1:0]  nxt_reg,     nxt_next;
    logic [IDX_W-1:0]  slot_reg,    slot_next;
    logic [VAL_W-1:0]  val_reg,     val_next;
    logic [STAT_W-1:0] status_reg,  status_next;
    logic [VAL_W-1:0]  removed_reg, removed_next;
    logic              m_valid_reg, m_valid_next;
    clpo_out_t         m_data_reg,  m_data_next;

    clpo_store_req_t   req;
    logic [IDX_W-1:0]  link_rdata;
    logic [VAL_W-1:0]  val_rdata;

    clpo_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .link_rdata (link_rdata),
        .val_rdata  (val_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        logic [CMP_W-1:0] pos_w;
        logic [CMP_W-1:0] cnt_w;
        logic [CMP_W-1:0] cnt_p1;
        logic             is_ins;
        logic             is_del;
        logic             at_front;
        logic             at_back;

        pos_w    = CMP_W'(s_data.position);
        cnt_w    = CMP_W'(count_reg);
        cnt_p1   = cnt_w + CMP_W'(1);
        is_ins   = (s_data.op <= OP_INS_POS);
        is_del   = (s_data.op >= OP_DEL_FRONT) && (s_data.op <= OP_DEL_POS);
        at_front = (s_data.op == OP_DEL_FRONT) ||
                   ((s_data.op == OP_DEL_POS) && (pos_w == CMP_W'(1)));
        at_back  = (s_data.op == OP_DEL_BACK) ||
                   ((s_data.op == OP_DEL_POS) && (pos_w == cnt_w));

        state_next   = state_reg;
        kind_next    = kind_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        slot_next    = slot_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        req          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next         = s_data.value;
                    status_next      = ST_DONE;
                    removed_next     = '0;
                    cur_next         = head_reg;
                    req.link_rd_en   = 1'b1;
                    req.link_rd_addr = is_ins ? free_reg : head_reg;
                    req.val_rd_en    = 1'b1;
                    req.val_rd_addr  = (at_back && !at_front) ? tail_reg : head_reg;
                    state_next       = S_EMIT;
                    priority if (is_ins) begin
                        priority if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = ST_FULL;
                        end else if ((s_data.op == OP_INS_FRONT) ||
                                     ((s_data.op == OP_INS_POS) &&
                                      (pos_w == CMP_W'(1)))) begin
                            state_next = S_INS_FRONT;
                        end else if ((s_data.op == OP_INS_BACK) ||
                                     ((s_data.op == OP_INS_POS) && (pos_w == cnt_p1))) begin
                            state_next = S_INS_BACK;
                        end else if ((pos_w != '0) && (pos_w <= cnt_w)) begin
                            kind_next        = WK_MID_INS;
                            steps_next       = CNT_W'(pos_w - CMP_W'(2));
                            // the walk starts from the head link
                            req.link_rd_addr = head_reg;
                            state_next       = S_WALK;
                        end else begin
                            status_next = ST_BADPOS;
                        end
                    end else if (is_del) begin
                        priority if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (at_front ||
                                     (at_back && (count_reg == CNT_W'(1)))) begin
                            state_next = S_DEL_FRONT;
                        end else if (at_back) begin
                            kind_next  = WK_DEL_BACK;
                            steps_next = count_reg - CNT_W'(2);
                            state_next = S_WALK;
                        end else if ((pos_w > CMP_W'(1)) && (pos_w < cnt_w)) begin
                            kind_next  = WK_MID_DEL;
                            steps_next = CNT_W'(pos_w - CMP_W'(2));
                            state_next = S_WALK;
                        end else begin
                            status_next = ST_BADPOS;
                        end
                    end else begin
                        status_next = ST_BADPOS;
                    end
                end
            end

            S_INS_FRONT: begin
                req.val_wr_en    = 1'b1;
                req.val_wr_addr  = free_reg;
                req.val_wr_data  = val_reg;
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = free_reg;
                req.link_wr_data = head_reg;
                head_next        = free_reg;
                if (count_reg == '0) begin
                    tail_next = free_reg;
                end
                free_next  = link_rdata;
                count_next = count_reg + 1'b1;
                state_next = S_EMIT;
            end

            S_INS_BACK: begin
                req.val_wr_en    = 1'b1;
                req.val_wr_addr  = free_reg;
                req.val_wr_data  = val_reg;
                req.link_wr_en   = (count_reg != '0);
                req.link_wr_addr = tail_reg;
                req.link_wr_data = free_reg;
                tail_next        = free_reg;
                if (count_reg == '0) begin
                    head_next = free_reg;
                end
                free_next  = link_rdata;
                count_next = count_reg + 1'b1;
                state_next = S_EMIT;
            end

            S_DEL_FRONT: begin
                removed_next     = val_rdata;
                head_next        = link_rdata;
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = head_reg;
                req.link_wr_data = free_reg;
                free_next        = head_reg;
                count_next       = count_reg - 1'b1;
                state_next       = S_EMIT;
            end

            S_WALK: begin
                // link_rdata always holds the successor of cur_reg here
                if (steps_reg == '0) begin
                    unique case (kind_reg)
                        WK_MID_INS: begin
                            nxt_next         = link_rdata;
                            req.link_rd_en   = 1'b1;
                            req.link_rd_addr = free_reg;
                            state_next       = S_MI_LINK;
                        end
                        WK_MID_DEL: begin
                            nxt_next         = link_rdata;
                            req.link_rd_en   = 1'b1;
                            req.link_rd_addr = link_rdata;
                            req.val_rd_en    = 1'b1;
                            req.val_rd_addr  = link_rdata;
                            state_next       = S_MD_UNLINK;
                        end
                        default: begin
                            // delete back: tail value was read at accept
                            removed_next     = val_rdata;
                            req.link_wr_en   = 1'b1;
                            req.link_wr_addr = tail_reg;
                            req.link_wr_data = free_reg;
                            free_next        = tail_reg;
                            tail_next        = cur_reg;
                            count_next       = count_reg - 1'b1;
                            state_next       = S_EMIT;
                        end
                    endcase
                end else begin
                    cur_next         = link_rdata;
                    steps_next       = steps_reg - 1'b1;
                    req.link_rd_en   = 1'b1;
                    req.link_rd_addr = link_rdata;
                end
            end

            S_MI_LINK: begin
                slot_next        = free_reg;
                free_next        = link_rdata;
                req.val_wr_en    = 1'b1;
                req.val_wr_addr  = free_reg;
                req.val_wr_data  = val_reg;
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = free_reg;
                req.link_wr_data = nxt_reg;
                state_next       = S_MI_SPLICE;
            end

            S_MI_SPLICE: begin
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = cur_reg;
                req.link_wr_data = slot_reg;
                count_next       = count_reg + 1'b1;
                state_next       = S_EMIT;
            end

            S_MD_UNLINK: begin
                removed_next     = val_rdata;
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = cur_reg;
                req.link_wr_data = link_rdata;
                state_next       = S_MD_FREE;
            end

            S_MD_FREE: begin
                req.link_wr_en   = 1'b1;
                req.link_wr_addr = nxt_reg;
                req.link_wr_data = free_reg;
                free_next        = nxt_reg;
                count_next       = count_reg - 1'b1;
                state_next       = S_EMIT;
            end

            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status        = status_reg;
                    m_data_next.count         = OUT_CNT_W'(count_reg);
                    m_data_next.removed_value = removed_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            free_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        steps_reg   <= steps_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        slot_reg    <= slot_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        m_data_reg  <= m_data_next;
    end

    `CLPO_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `CLPO_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready, "sequencer idle after accept")
    `CLPO_ASSERT_NOW(a_full_count, m_valid && (m_data.status == ST_FULL), m_data.count == OUT_CNT_W'(CAPACITY), "full status with room left")
    `CLPO_ASSERT_NOW(a_empty_count, m_valid && (m_data.status == ST_EMPTY), m_data.count == '0, "empty status with items held")
    `CLPO_ASSERT_NOW(a_removed_zero, m_valid && (m_data.status != ST_DONE), m_data.removed_value == '0, "removed value on rejected word")

endmodule

`default_nettype wire

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb - circular_list_position_ops testbench
// Drives insert, delete and unused-op requests with random gaps and receiver stalls,
// keeps its own ordered copy of the list, and checks every result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpo_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int RANDOM_WORDS = 500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;

    // Ordered copy of the list plus the queue of result words still owed.
    class list_tracker;
        logic signed [VAL_W-1:0] contents[$];
        clpo_out_t               due[$];
        int                      errors;

        function int held();
            return contents.size();
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        function void note_request(clpo_in_t w);
            clpo_out_t r;
            int        n;
            int        p;
            n = contents.size();
            p = w.position;
            r.status = ST_DONE;
            r.removed_value = '0;
            case (w.op)
                OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                    if (n >= CAPACITY)
                        r.status = ST_FULL;
                    else if (w.op == OP_INS_FRONT)
                        contents.push_front(w.value);
                    else if (w.op == OP_INS_BACK)
                        contents.push_back(w.value);
                    else if (p == 0 || p > n + 1)
                        r.status = ST_BADPOS;
                    else
                        contents.insert(p - 1, w.value);
                end
                OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                    if (n == 0)
                        r.status = ST_EMPTY;
                    else if (w.op == OP_DEL_FRONT)
                        r.removed_value = contents.pop_front();
                    else if (w.op == OP_DEL_BACK)
                        r.removed_value = contents.pop_back();
                    else if (p == 0 || p > n)
                        r.status = ST_BADPOS;
                    else begin
                        r.removed_value = contents[p - 1];
                        contents.delete(p - 1);
                    end
                end
                default: r.status = ST_BADPOS;
            endcase
            r.count = OUT_CNT_W'(contents.size());
            due.push_back(r);
        endfunction

        function void check_reply(clpo_out_t got);
            clpo_out_t want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result word status=%0d count=%0d removed=%0d",
                             got.status, got.count, got.removed_value);
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status || got.count !== want.count ||
                got.removed_value !== want.removed_value) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: status %0d/%0d count %0d/%0d removed %0d/%0d (exp/got)",
                             want.status, got.status, want.count, got.count,
                             want.removed_value, got.removed_value);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    clpo_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    clpo_out_t m_data;

    list_tracker board;
    int          cycles;

    circular_list_position_ops dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic clpo_in_t make_word(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                           logic [POS_W-1:0] p);
        clpo_in_t w;
        w.op = op;
        w.value = v;
        w.position = p;
        return w;
    endfunction

    // Mostly short gaps, a few long ones; zero inside a burst stretch.
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 80);
    endfunction

    task automatic send_word(clpo_in_t w, int idle, bit hold_off);
        if (hold_off) begin
            // let the block fully drain before the next word
            s_valid <= 1'b0;
            do @(posedge aclk); while (board.outstanding() != 0);
        end else if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_request(w);
    endtask

    task automatic receive_words();
        int got_words;
        int idle;
        got_words = 0;
        forever begin
            idle = pick_gap((got_words / 50) % 3 == 2);
            if (idle > 0) begin
                m_ready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_reply(m_data);
            got_words++;
        end
    endtask

    function automatic clpo_in_t random_word(bit filling);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] p;
        int               r;
        int               n;
        n = board.held();
        r = $urandom_range(0, 99);
        if (r < (filling ? 75 : 25))
            op = OP_W'($urandom_range(0, 2));
        else if (r < 95)
            op = OP_W'($urandom_range(3, 5));
        else
            op = OP_W'($urandom_range(0, 7));
        p = POS_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 88) begin
            if (op == OP_INS_POS && n < CAPACITY)
                p = POS_W'($urandom_range(1, n + 1));
            else if (op == OP_DEL_POS && n > 0)
                p = POS_W'($urandom_range(1, n));
        end
        return make_word(op, $urandom(), p);
    endfunction

    initial begin
        clpo_in_t directed[$];
        bit       filling;
        int       n;

        board   = new();
        cycles  = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fork
            receive_words();
        join_none

        // empty list: every delete is refused, unused ops, bad insert slots
        directed.push_back(make_word(OP_DEL_FRONT, 32'sd0, 7'd0));
        directed.push_back(make_word(OP_DEL_BACK, 32'sd5, 7'd0));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd0));
        directed.push_back(make_word(OP_SPARE_6, 32'sd1, 7'd1));
        directed.push_back(make_word(OP_SPARE_7, -32'sd1, 7'd127));
        directed.push_back(make_word(OP_INS_POS, 32'sd9, 7'd0));
        directed.push_back(make_word(OP_INS_POS, 32'sd9, 7'd2));
        // build five entries through every insert path
        directed.push_back(make_word(OP_INS_POS, 32'sh7FFFFFFF, 7'd1));
        directed.push_back(make_word(OP_INS_FRONT, 32'sh80000000, 7'd0));
        directed.push_back(make_word(OP_INS_BACK, -32'sd1, 7'd127));
        directed.push_back(make_word(OP_INS_POS, 32'sd0, 7'd4));
        directed.push_back(make_word(OP_INS_POS, 32'sh55555555, 7'd2));
        directed.push_back(make_word(OP_INS_POS, 32'sh2AAAAAAA, 7'd127));
        directed.push_back(make_word(OP_INS_POS, 32'sd3, 7'd7));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd0));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd6));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd65));
        directed.push_back(make_word(OP_SPARE_6, 32'sd0, 7'd2));
        // tear down: middle, last by position, first by position, front, back, then a back delete on the empty list
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd3));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd4));
        directed.push_back(make_word(OP_DEL_POS, 32'sd0, 7'd1));
        directed.push_back(make_word(OP_DEL_FRONT, 32'sd0, 7'd0));
        directed.push_back(make_word(OP_DEL_BACK, 32'sd0, 7'd0));
        directed.push_back(make_word(OP_DEL_BACK, 32'sd0, 7'd0));

        foreach (directed[i])
            send_word(directed[i], pick_gap(1'b0), 1'b0);

        // random part swings the list between empty and full
        filling = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            n = board.held();
            if (filling && n == CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && n == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            send_word(random_word(filling), pick_gap((i / 40) % 4 == 3),
                      i == RANDOM_WORDS / 2 || i == RANDOM_WORDS - 20);
        end

        s_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: circular_list_position_ops.f
+incdir+src
src/clpo_pkg.sv
src/clpo_store.sv
src/circular_list_position_ops.sv
test/tb.sv
